// ===== rtl/rmq_pkg.sv =====
// Shared types and constants for the rotation matrix to quaternion block.
// Used by rmq_prep, rmq_sqrt, rmq_div and the top level; no dependencies.
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int WordW      = 16;
  localparam int FracW      = WordW - 2;
  localparam int NumW       = WordW + 2;       // sums and differences of elements
  localparam int RadW       = 32;              // sqrt radicand
  localparam int RootW      = 16;
  localparam int SqrtStages = RootW;
  localparam int QuotW      = WordW;
  localparam int DivStages  = QuotW + 1;       // setup stage plus one per quotient bit
  localparam int DenW       = RootW + 1;
  localparam int RemW       = 34;

  typedef struct packed {
    logic signed [WordW-1:0] m00;
    logic signed [WordW-1:0] m01;
    logic signed [WordW-1:0] m02;
    logic signed [WordW-1:0] m10;
    logic signed [WordW-1:0] m11;
    logic signed [WordW-1:0] m12;
    logic signed [WordW-1:0] m20;
    logic signed [WordW-1:0] m21;
    logic signed [WordW-1:0] m22;
  } rmq_in_t;

  typedef struct packed {
    logic signed [WordW-1:0] quat_w;
    logic signed [WordW-1:0] quat_x;
    logic signed [WordW-1:0] quat_y;
    logic signed [WordW-1:0] quat_z;
  } rmq_out_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } pipe_ctl_t;

endpackage

// ===== rtl/rmq_prep.sv =====
// First pipeline stage: trace, branch choice, sqrt radicand and numerators.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
module rmq_prep (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  rmq_pkg::pipe_ctl_t                      ctl_i,
  input  rmq_pkg::rmq_in_t                        mat_i,
  output logic                                    valid_o,
  output logic [rmq_pkg::RadW-1:0]                rad_o,
  output logic [3:0][rmq_pkg::NumW-1:0]           num_o,
  output logic [1:0]                              diag_idx_o
);

  logic                                 valid_q;
  logic [rmq_pkg::RadW-1:0]             rad_q, rad_d;
  logic [3:0][rmq_pkg::NumW-1:0]        num_q, num_d;
  logic [1:0]                           diag_idx_q, diag_idx_d;

  logic signed [rmq_pkg::NumW-1:0] e00, e11, e22, tr, mii;
  logic signed [rmq_pkg::NumW-1:0] dx, dy, dz, sxy, sxz, syz;
  logic signed [rmq_pkg::NumW:0]   arg;

  always_comb begin
    e00 = rmq_pkg::NumW'(mat_i.m00);
    e11 = rmq_pkg::NumW'(mat_i.m11);
    e22 = rmq_pkg::NumW'(mat_i.m22);
    tr  = e00 + e11 + e22;
    dx  = rmq_pkg::NumW'(mat_i.m21) - rmq_pkg::NumW'(mat_i.m12);
    dy  = rmq_pkg::NumW'(mat_i.m02) - rmq_pkg::NumW'(mat_i.m20);
    dz  = rmq_pkg::NumW'(mat_i.m10) - rmq_pkg::NumW'(mat_i.m01);
    sxy = rmq_pkg::NumW'(mat_i.m01) + rmq_pkg::NumW'(mat_i.m10);
    sxz = rmq_pkg::NumW'(mat_i.m02) + rmq_pkg::NumW'(mat_i.m20);
    syz = rmq_pkg::NumW'(mat_i.m12) + rmq_pkg::NumW'(mat_i.m21);
    mii = e00;
    num_d = '0;
    if (tr > 0) begin
      diag_idx_d = 2'd0;
      arg = (rmq_pkg::NumW+1)'(tr) + (rmq_pkg::NumW+1)'(1 << rmq_pkg::FracW);
      num_d[1] = dx;
      num_d[2] = dy;
      num_d[3] = dz;
    end else begin
      // largest diagonal, ties keep the lower index
      diag_idx_d = 2'd1;
      if (e11 > e00) begin
        diag_idx_d = 2'd2;
        mii = e11;
      end
      if (e22 > mii) begin
        diag_idx_d = 2'd3;
        mii = e22;
      end
      arg = ((rmq_pkg::NumW+1)'(mii) <<< 1) - (rmq_pkg::NumW+1)'(tr)
          + (rmq_pkg::NumW+1)'(1 << rmq_pkg::FracW);
      case (diag_idx_d)
        2'd1: begin
          num_d[0] = dx; num_d[2] = sxy; num_d[3] = sxz;
        end
        2'd2: begin
          num_d[0] = dy; num_d[3] = syz; num_d[1] = sxy;
        end
        default: begin
          num_d[0] = dz; num_d[1] = sxz; num_d[2] = syz;
        end
      endcase
    end
    if (arg > 0) begin
      rad_d = rmq_pkg::RadW'({arg[16:0], {rmq_pkg::FracW{1'b0}}});
    end else begin
      rad_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.advance) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      rad_q      <= rad_d;
      num_q      <= num_d;
      diag_idx_q <= diag_idx_d;
    end
  end

  assign valid_o    = valid_q;
  assign rad_o      = rad_q;
  assign num_o      = num_q;
  assign diag_idx_o = diag_idx_q;

endmodule

// ===== rtl/rmq_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
module rmq_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rmq_pkg::pipe_ctl_t            ctl_i,
  input  logic [rmq_pkg::RadW-1:0]      rad_i,
  output logic                          valid_o,
  output logic [rmq_pkg::RootW-1:0]     root_o
);

  logic                           vld_q  [rmq_pkg::SqrtStages];
  logic [rmq_pkg::RemW-1:0]       rem_q  [rmq_pkg::SqrtStages];
  logic [rmq_pkg::RootW-1:0]      root_q [rmq_pkg::SqrtStages];

  for (genvar g = 0; g < rmq_pkg::SqrtStages; g++) begin : g_stage
    localparam int B = rmq_pkg::SqrtStages - 1 - g;
    logic                      vld_in;
    logic [rmq_pkg::RemW-1:0]  rem_in, trial, rem_d;
    logic [rmq_pkg::RootW-1:0] root_in, root_d;

    if (g == 0) begin : g_first
      assign vld_in  = ctl_i.valid;
      assign rem_in  = rmq_pkg::RemW'(rad_i);
      assign root_in = '0;
    end else begin : g_next
      assign vld_in  = vld_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
    end

    // (r + 2^B)^2 - r^2
    always_comb begin
      trial = (rmq_pkg::RemW'(root_in) << (B + 1)) + (rmq_pkg::RemW'(1) << (2 * B));
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = root_in | (rmq_pkg::RootW'(1) << B);
      end else begin
        rem_d  = rem_in;
        root_d = root_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (ctl_i.advance) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.advance) begin
        rem_q[g]  <= rem_d;
        root_q[g] <= root_d;
      end
    end
  end

  assign valid_o = vld_q[rmq_pkg::SqrtStages-1];
  assign root_o  = root_q[rmq_pkg::SqrtStages-1];

endmodule

// ===== rtl/rmq_div.sv =====
// Pipelined restoring divider for d * 2^F / (2s), rounded half away from zero.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
module rmq_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rmq_pkg::pipe_ctl_t                ctl_i,
  input  logic [rmq_pkg::NumW-1:0]          num_i,
  input  logic [rmq_pkg::RootW-1:0]         root_i,
  output logic                              valid_o,
  output logic [rmq_pkg::QuotW-1:0]         quot_o,
  output logic                              ovf_o,
  output logic                              neg_o
);

  localparam int Steps = rmq_pkg::DivStages - 1;

  logic                          vld_q  [rmq_pkg::DivStages];
  logic [rmq_pkg::RemW-1:0]      rem_q  [rmq_pkg::DivStages];
  logic [rmq_pkg::DenW-1:0]      den_q  [rmq_pkg::DivStages];
  logic [rmq_pkg::QuotW-1:0]     quot_q [rmq_pkg::DivStages];
  logic                          ovf_q  [rmq_pkg::DivStages];
  logic                          neg_q  [rmq_pkg::DivStages];

  // setup: magnitude, rounding bias and quotient overflow
  logic                         neg0;
  logic [rmq_pkg::NumW-1:0]     mag0;
  logic [rmq_pkg::RemW-1:0]     rem0;
  logic [rmq_pkg::DenW-1:0]     den0;

  always_comb begin
    neg0 = num_i[rmq_pkg::NumW-1];
    mag0 = neg0 ? (rmq_pkg::NumW'(0) - num_i) : num_i;
    rem0 = (rmq_pkg::RemW'(mag0) << rmq_pkg::FracW) + rmq_pkg::RemW'(root_i);
    den0 = {root_i, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (ctl_i.advance) begin
      vld_q[0] <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      rem_q[0]  <= rem0;
      den_q[0]  <= den0;
      quot_q[0] <= '0;
      ovf_q[0]  <= rem0 >= (rmq_pkg::RemW'(den0) << rmq_pkg::QuotW);
      neg_q[0]  <= neg0;
    end
  end

  for (genvar g = 1; g < rmq_pkg::DivStages; g++) begin : g_step
    localparam int B = Steps - g;
    logic [rmq_pkg::RemW-1:0]  trial, rem_d;
    logic [rmq_pkg::QuotW-1:0] quot_d;

    always_comb begin
      trial = rmq_pkg::RemW'(den_q[g-1]) << B;
      if (rem_q[g-1] >= trial) begin
        rem_d  = rem_q[g-1] - trial;
        quot_d = quot_q[g-1] | (rmq_pkg::QuotW'(1) << B);
      end else begin
        rem_d  = rem_q[g-1];
        quot_d = quot_q[g-1];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (ctl_i.advance) begin
        vld_q[g] <= vld_q[g-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.advance) begin
        rem_q[g]  <= rem_d;
        den_q[g]  <= den_q[g-1];
        quot_q[g] <= quot_d;
        ovf_q[g]  <= ovf_q[g-1];
        neg_q[g]  <= neg_q[g-1];
      end
    end
  end

  assign valid_o = vld_q[rmq_pkg::DivStages-1];
  assign quot_o  = quot_q[rmq_pkg::DivStages-1];
  assign ovf_o   = ovf_q[rmq_pkg::DivStages-1];
  assign neg_o   = neg_q[rmq_pkg::DivStages-1];

endmodule

// ===== rtl/rotation_matrix_to_quaternion_unit.sv =====
// Top level of the rotation matrix to quaternion converter (Shepperd's method).
// Depends on rmq_pkg, rmq_prep, rmq_sqrt and rmq_div.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o / in_data_i carry one request, a
//   3x3 matrix of signed Q2.14 elements. Output channel: out_valid_o /
//   out_stall_i / out_data_o carry the quaternion (w, x, y, z) in Q2.14,
//   saturated. A request moves when valid is high and stall is low.
//   From acceptance to out_valid_o a request passes one prep stage,
//   16 square-root stages (one root bit each), 17 divider stages (overflow
//   setup plus one quotient bit each) and the output register.
//   Throughput is one request per cycle unless the receiver stalls; the
//   bit-per-stage square root and the four divider lanes are fully
//   pipelined, so nothing iterates in place. Reset clears every valid bit;
//   data registers are not reset. When the receiver stalls with a result
//   waiting, the whole pipeline holds and in_stall_o rises in the same
//   cycle; no request is dropped or repeated. A stall from the receiver
//   does not block the pipeline when the output register is empty.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rmq_pkg::rmq_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rmq_pkg::rmq_out_t  out_data_o
);

  // side data that rides along the square root
  typedef struct packed {
    logic [3:0][rmq_pkg::NumW-1:0] num;
    logic [1:0]                    diag_idx;
  } side_sqrt_t;

  // side data that rides along the dividers
  typedef struct packed {
    logic [rmq_pkg::QuotW-1:0] diag;
    logic [1:0]                diag_idx;
    logic                      zero;
  } side_div_t;

  logic advance;
  rmq_pkg::pipe_ctl_t ctl_in, ctl_sqrt, ctl_div;

  logic                              prep_valid;
  logic [rmq_pkg::RadW-1:0]          prep_rad;
  logic [3:0][rmq_pkg::NumW-1:0]     prep_num;
  logic [1:0]                        prep_idx;

  logic                              sqrt_valid;
  logic [rmq_pkg::RootW-1:0]         sqrt_root;

  side_sqrt_t side1_q [rmq_pkg::SqrtStages];
  side_div_t  side2_q [rmq_pkg::DivStages];
  side_div_t  side2_d;

  logic                              div_valid;
  logic [3:0][rmq_pkg::QuotW-1:0]    quot;
  logic [3:0]                        ovf, neg;

  logic              out_valid_q;
  rmq_pkg::rmq_out_t out_data_q, out_data_d;
  logic [3:0][rmq_pkg::WordW-1:0] comp;

  // hold every stage while a finished result waits on a stalled receiver
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;

  assign ctl_in   = '{valid: in_valid_i, advance: advance};
  assign ctl_sqrt = '{valid: prep_valid, advance: advance};
  assign ctl_div  = '{valid: sqrt_valid, advance: advance};

  rmq_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl_in),
    .mat_i      (in_data_i),
    .valid_o    (prep_valid),
    .rad_o      (prep_rad),
    .num_o      (prep_num),
    .diag_idx_o (prep_idx)
  );

  rmq_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_sqrt),
    .rad_i   (prep_rad),
    .valid_o (sqrt_valid),
    .root_o  (sqrt_root)
  );

  // numerators and diagonal slot follow the root through its stages
  always_ff @(posedge clk_i) begin
    if (advance) begin
      side1_q[0] <= '{num: prep_num, diag_idx: prep_idx};
      for (int s = 1; s < rmq_pkg::SqrtStages; s++) begin
        side1_q[s] <= side1_q[s-1];
      end
    end
  end

  // four lanes, one per quaternion part; the diagonal slot's lane is ignored
  for (genvar p = 0; p < 4; p++) begin : g_lane
    if (p == 0) begin : g_main
      rmq_div u_div (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctl_i   (ctl_div),
        .num_i   (side1_q[rmq_pkg::SqrtStages-1].num[p]),
        .root_i  (sqrt_root),
        .valid_o (div_valid),
        .quot_o  (quot[p]),
        .ovf_o   (ovf[p]),
        .neg_o   (neg[p])
      );
    end else begin : g_aux
      rmq_div u_div (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctl_i   (ctl_div),
        .num_i   (side1_q[rmq_pkg::SqrtStages-1].num[p]),
        .root_i  (sqrt_root),
        .valid_o (),
        .quot_o  (quot[p]),
        .ovf_o   (ovf[p]),
        .neg_o   (neg[p])
      );
    end
  end

  // diagonal term is the root halved, rounded half up
  always_comb begin
    side2_d.diag     = rmq_pkg::QuotW'(({1'b0, sqrt_root} + 17'd1) >> 1);
    side2_d.diag_idx = side1_q[rmq_pkg::SqrtStages-1].diag_idx;
    side2_d.zero     = (sqrt_root == '0);
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      side2_q[0] <= side2_d;
      for (int s = 1; s < rmq_pkg::DivStages; s++) begin
        side2_q[s] <= side2_q[s-1];
      end
    end
  end

  // saturate a signed quotient to the word range
  function automatic logic [rmq_pkg::WordW-1:0] sat_quot(
    input logic [rmq_pkg::QuotW-1:0] q,
    input logic                      o,
    input logic                      n
  );
    logic [rmq_pkg::WordW-1:0] r;
    if (n) begin
      if (o || (q > (rmq_pkg::QuotW'(1) << (rmq_pkg::QuotW - 1)))) begin
        r = {1'b1, {(rmq_pkg::WordW-1){1'b0}}};
      end else begin
        r = rmq_pkg::WordW'(0) - q;
      end
    end else begin
      if (o || q[rmq_pkg::QuotW-1]) begin
        r = {1'b0, {(rmq_pkg::WordW-1){1'b1}}};
      end else begin
        r = q;
      end
    end
    return r;
  endfunction

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      if (side2_q[rmq_pkg::DivStages-1].zero) begin
        comp[p] = '0;
      end else if (side2_q[rmq_pkg::DivStages-1].diag_idx == 2'(p)) begin
        comp[p] = side2_q[rmq_pkg::DivStages-1].diag;
      end else begin
        comp[p] = sat_quot(quot[p], ovf[p], neg[p]);
      end
    end
    out_data_d.quat_w = comp[0];
    out_data_d.quat_x = comp[1];
    out_data_d.quat_y = comp[2];
    out_data_d.quat_z = comp[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
